[src/assert_macros.svh]
// Assertion macros shared by the dose sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DCS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DCS_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define DCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define DCS_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

[src/dcs_pkg.sv]
// Types and constants shared by the dose sequencer files.
package dcs_pkg;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_REPORT  = 2'd1;
    localparam logic [1:0] ACT_OFFLINE = 2'd2;
    localparam logic [1:0] ACT_CLEAR   = 2'd3;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PREHEAT = 2'd1;
    localparam logic [1:0] PH_WAIT    = 2'd2;
    localparam logic [1:0] PH_DOSE    = 2'd3;

    localparam logic [1:0] CFG_PREHEAT = 2'd0;
    localparam logic [1:0] CFG_SAFETY  = 2'd1;
    localparam logic [1:0] CFG_DOSE    = 2'd2;
    localparam logic [1:0] CFG_ENABLE  = 2'd3;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [15:0] RST_PREHEAT = 16'd4000;
    localparam logic [15:0] RST_SAFETY  = 16'd10000;
    localparam logic [15:0] RST_DOSE    = 16'd11500;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] unit_addr;
        logic       cart_one;
        logic       cart_two;
        logic       person_seen;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [4:0] cmd_unit;
        logic [1:0] cmd_channel;
        logic       pump_on;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] preheat_ticks;
        logic [15:0] safety_wait_ticks;
        logic [15:0] dose_ticks;
        logic        safety_enable;
    } t_cfg;

    typedef struct packed {
        logic is_tick;
        logic online;
        logic human;
        logic cart_bit;
    } t_step_ctl;

    typedef struct packed {
        logic start;
        logic dosing;
    } t_step_flags;

endpackage

[src/dcs_in_if.sv]
// Input item channel of the dose sequencer.
interface dcs_in_if;
    logic               valid;
    logic               ready;
    dcs_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/dcs_out_if.sv]
// Result item channel of the dose sequencer.
interface dcs_out_if;
    logic               valid;
    logic               ready;
    dcs_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/multi_channel_dose_sequencer.sv]
// Top level of the dose sequencer: channel table, walk sequencer and result register.
// A tick walks every channel through one shared step unit, one channel per cycle while the
// result register can take a start item. A valid status report walks its unit's two
// channels; offline, clear and an invalid report go straight to the summary. Input is
// ready again in the cycle after the summary is loaded.
// Reset is synchronous; per-entry valid bits make entries read as idle, so no clearing pass.
`include "assert_macros.svh"

module multi_channel_dose_sequencer #(
    parameter int UNITS      = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    dcs_in_if.sink      i_in,
    dcs_out_if.source   o_res
);
    import dcs_pkg::*;

    localparam int NCHAN = 2 * UNITS;
    localparam int CH_W  = $clog2(NCHAN);
    localparam int CA_W  = $clog2(NCHAN + 1);
    localparam int UW    = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam int EW    = COUNT_BITS + 3;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_SUM  = 2'd2;

    logic [1:0]       r_state;
    t_cfg             r_cfg;
    logic [1:0]       r_act;
    logic             r_human;
    logic             r_c1;
    logic             r_c2;
    logic [CA_W-1:0]  r_ra;
    logic [CA_W-1:0]  r_end;
    logic [CH_W-1:0]  r_pc;
    logic             r_pipe_v;
    logic             r_rd_ok;
    logic [EW-1:0]    r_rdata;
    logic [EW-1:0]    r_mem [NCHAN];
    logic [NCHAN-1:0] r_valid;
    logic [NCHAN-1:0] r_cart;
    logic [UNITS-1:0] r_online;
    logic             r_pump;
    logic             r_any;
    logic             r_ov;
    t_out_item        r_od;

    t_in_item         in_d;
    logic             addr_ok;
    logic [UW-1:0]    addr_u;
    logic [UW-1:0]    pc_u;
    logic             out_free;
    logic             advance;
    logic             rd_en;
    logic             mem_we;
    logic             load_out;
    t_out_item        out_next;

    t_step_ctl              step_ctl;
    t_step_flags            step_flags;
    logic [1:0]             e_phase;
    logic                   e_wait;
    logic [COUNT_BITS-1:0]  e_count;
    logic [1:0]             u_phase;
    logic                   u_wait;
    logic [COUNT_BITS-1:0]  u_count;
    logic                   u_cart;

    assign in_d    = i_in.data;
    assign addr_ok = (in_d.unit_addr != 5'd0) && (32'(in_d.unit_addr) <= 32'(UNITS));
    assign addr_u  = UW'(in_d.unit_addr - 5'd1);
    assign pc_u    = UW'(r_pc >> 1);

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_res.valid = r_ov;
    assign o_res.data  = r_od;

    assign out_free = !r_ov || o_res.ready;
    assign advance  = !(r_pipe_v && step_flags.start && !out_free);
    assign rd_en    = (r_state == S_WALK) && advance && (r_ra != r_end);
    assign mem_we   = (r_state == S_WALK) && advance && r_pipe_v;
    assign load_out = ((r_state == S_WALK) && r_pipe_v && step_flags.start && out_free) ||
                      ((r_state == S_SUM) && out_free);

    assign e_phase = r_rd_ok ? r_rdata[EW-1 -: 2] : PH_IDLE;
    assign e_wait  = r_rd_ok & r_rdata[COUNT_BITS];
    assign e_count = r_rd_ok ? r_rdata[COUNT_BITS-1:0] : '0;

    assign step_ctl.is_tick  = (r_act == ACT_TICK);
    assign step_ctl.online   = r_online[pc_u];
    assign step_ctl.human    = r_human;
    assign step_ctl.cart_bit = r_pc[0] ? r_c2 : r_c1;

    dcs_chan_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_chan_unit (
        .i_cfg   (r_cfg),
        .i_ctl   (step_ctl),
        .i_phase (e_phase),
        .i_wait  (e_wait),
        .i_count (e_count),
        .i_cart  (r_cart[r_pc]),
        .o_phase (u_phase),
        .o_wait  (u_wait),
        .o_count (u_count),
        .o_cart  (u_cart),
        .o_flags (step_flags)
    );

    always_comb begin
        if (r_state == S_WALK) begin
            out_next.kind        = KIND_START;
            out_next.cmd_unit    = 5'(r_pc >> 1) + 5'd1;
            out_next.cmd_channel = r_pc[0] ? 2'd2 : 2'd1;
            out_next.pump_on     = 1'b1;
            out_next.last        = 1'b0;
        end else begin
            out_next.kind        = KIND_SUMMARY;
            out_next.cmd_unit    = 5'd0;
            out_next.cmd_channel = 2'd0;
            out_next.pump_on     = r_pump;
            out_next.last        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_pc] <= {u_phase, u_wait, u_count};
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_ra[CH_W-1:0]];
            r_rd_ok <= r_valid[r_ra[CH_W-1:0]];
        end
        if (load_out) begin
            r_od <= out_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= '{RST_PREHEAT, RST_SAFETY, RST_DOSE, 1'b1};
            r_act    <= ACT_TICK;
            r_human  <= 1'b0;
            r_c1     <= 1'b0;
            r_c2     <= 1'b0;
            r_ra     <= '0;
            r_end    <= '0;
            r_pc     <= '0;
            r_pipe_v <= 1'b0;
            r_valid  <= '0;
            r_cart   <= '0;
            r_online <= '0;
            r_pump   <= 1'b0;
            r_any    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PREHEAT: r_cfg.preheat_ticks     <= i_cfg_data;
                    CFG_SAFETY:  r_cfg.safety_wait_ticks <= i_cfg_data;
                    CFG_DOSE:    r_cfg.dose_ticks        <= i_cfg_data;
                    CFG_ENABLE:  r_cfg.safety_enable     <= i_cfg_data[0];
                    default:     r_cfg                   <= r_cfg;
                endcase
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_act    <= in_d.action;
                        r_human  <= r_cfg.safety_enable & in_d.person_seen;
                        r_c1     <= in_d.cart_one;
                        r_c2     <= in_d.cart_two;
                        r_pipe_v <= 1'b0;
                        unique case (in_d.action)
                            ACT_TICK: begin
                                r_ra    <= '0;
                                r_end   <= CA_W'(NCHAN);
                                r_any   <= 1'b0;
                                r_state <= S_WALK;
                            end
                            ACT_REPORT: begin
                                if (addr_ok) begin
                                    r_online[addr_u] <= 1'b1;
                                    r_ra    <= CA_W'({addr_u, 1'b0});
                                    r_end   <= CA_W'({addr_u, 1'b0}) + CA_W'(2);
                                    r_state <= S_WALK;
                                end else begin
                                    r_state <= S_SUM;
                                end
                            end
                            ACT_OFFLINE: begin
                                if (addr_ok) begin
                                    r_online[addr_u] <= 1'b0;
                                end
                                r_state <= S_SUM;
                            end
                            ACT_CLEAR: begin
                                r_valid <= '0;
                                r_pump  <= 1'b0;
                                r_state <= S_SUM;
                            end
                            default: r_state <= S_SUM;
                        endcase
                    end
                end
                S_WALK: begin
                    if (advance) begin
                        if (r_pipe_v) begin
                            r_valid[r_pc] <= 1'b1;
                            r_cart[r_pc]  <= u_cart;
                            r_any         <= r_any | step_flags.dosing;
                        end
                        if (r_ra != r_end) begin
                            r_pipe_v <= 1'b1;
                            r_pc     <= r_ra[CH_W-1:0];
                            r_ra     <= r_ra + CA_W'(1);
                        end else begin
                            r_pipe_v <= 1'b0;
                            if (!r_pipe_v) begin
                                if (r_act == ACT_TICK) begin
                                    r_pump <= r_any;
                                end
                                r_state <= S_SUM;
                            end
                        end
                    end
                end
                S_SUM: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `DCS_ASSERT(a_walk_bound, i_clk, i_rst_n, (r_state == S_WALK) |-> (r_ra <= r_end), "Walk address ran past its end")
    `DCS_ASSERT(a_sum_loaded, i_clk, i_rst_n, $rose(r_state == S_IDLE) |-> (r_ov && r_od.last), "Summary item missing at end of item")
    `DCS_ASSERT(a_start_online, i_clk, i_rst_n, (r_state == S_WALK && r_pipe_v && step_flags.start) |-> (step_ctl.online && step_ctl.is_tick), "Dosing start for an offline unit")
    `DCS_NEVER(a_idle_pipe, i_clk, i_rst_n, i_in.ready && r_pipe_v, "Channel pipeline busy while ready")

endmodule

[src/dcs_chan_unit.sv]
// Shared channel step unit: computes the next state of one channel.
module dcs_chan_unit #(
    parameter int COUNT_BITS = 16
) (
    input  dcs_pkg::t_cfg          i_cfg,
    input  dcs_pkg::t_step_ctl     i_ctl,
    input  logic [1:0]             i_phase,
    input  logic                   i_wait,
    input  logic [COUNT_BITS-1:0]  i_count,
    input  logic                   i_cart,
    output logic [1:0]             o_phase,
    output logic                   o_wait,
    output logic [COUNT_BITS-1:0]  o_count,
    output logic                   o_cart,
    output dcs_pkg::t_step_flags   o_flags
);
    import dcs_pkg::*;

    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [CW-1:0] pre_th;
    logic [CW-1:0] wait_th;
    logic [CW-1:0] dose_th;

    assign pre_th  = CW'(i_cfg.preheat_ticks);
    assign wait_th = CW'(i_cfg.safety_wait_ticks);
    assign dose_th = CW'(i_cfg.dose_ticks);

    always_comb begin
        o_phase = i_phase;
        o_wait  = i_wait;
        o_count = i_count;
        o_cart  = i_cart;
        o_flags = '0;
        if (i_ctl.is_tick) begin
            if (o_phase == PH_PREHEAT || o_phase == PH_DOSE ||
                (o_phase == PH_WAIT && o_wait)) begin
                if (o_count != '1) begin
                    o_count = o_count + COUNT_BITS'(1);
                end
            end
            if (i_ctl.online) begin
                if (o_phase == PH_PREHEAT && CW'(o_count) >= pre_th) begin
                    if (i_ctl.human) begin
                        o_phase = PH_WAIT;
                        o_wait  = 1'b0;
                    end else begin
                        o_flags.start = 1'b1;
                    end
                end
                if (o_phase == PH_WAIT) begin
                    if (i_ctl.human) begin
                        o_wait = 1'b0;
                    end else if (!o_wait) begin
                        o_wait  = 1'b1;
                        o_count = '0;
                    end else if (CW'(o_count) >= wait_th) begin
                        o_flags.start = 1'b1;
                    end
                end
                if (o_flags.start) begin
                    o_phase = PH_DOSE;
                    o_wait  = 1'b0;
                    o_count = '0;
                end
                if (o_phase == PH_DOSE) begin
                    if (CW'(o_count) >= dose_th) begin
                        o_phase = PH_IDLE;
                    end else begin
                        o_flags.dosing = 1'b1;
                    end
                end
            end
        end else begin
            if (i_ctl.cart_bit && !i_cart) begin
                o_cart  = 1'b1;
                o_phase = PH_PREHEAT;
                o_count = '0;
                o_wait  = 1'b0;
            end else if (!i_ctl.cart_bit && i_cart) begin
                o_cart  = 1'b0;
                o_phase = PH_IDLE;
                o_count = '0;
                o_wait  = 1'b0;
            end
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the multi-channel dose sequencer, with a predictor and random traffic.
module testbench;
    import dcs_pkg::*;

    localparam int NUM_UNITS   = 16;
    localparam int NUM_CHAN    = 2 * NUM_UNITS;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 66;
    localparam int HOLD_CYCLES = 400;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = CFG_PREHEAT;
    logic [15:0] i_cfg_data = '0;
    logic        in_valid   = 1'b0;
    t_in_item    in_data    = '0;
    logic        res_ready  = 1'b0;

    dcs_in_if  in_ch ();
    dcs_out_if res_ch ();

    assign in_ch.valid  = in_valid;
    assign in_ch.data   = in_data;
    assign res_ch.ready = res_ready;

    multi_channel_dose_sequencer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_res      (res_ch)
    );

    logic [1:0]  ch_phase [NUM_CHAN];
    logic        ch_cart  [NUM_CHAN];
    logic        ch_armed [NUM_CHAN];
    logic [15:0] ch_ticks [NUM_CHAN];
    logic        unit_live [NUM_UNITS];
    logic        pump_live;
    logic [15:0] set_preheat;
    logic [15:0] set_wait;
    logic [15:0] set_dose;
    logic        set_guard;

    t_out_item awaited_msgs [$];
    t_in_item  pending_items [$];

    int   items_sent  = 0;
    int   items_taken = 0;
    int   cycle_count = 0;
    int   fail_count  = 0;
    int   hold_left   = 0;
    bit   hold_done   = 1'b0;
    logic calm;

    assign calm = (cycle_count % 6000) < 1500;

    always #5 i_clk = ~i_clk;

    task automatic apply_cart(input int c, input logic level);
        if (level && !ch_cart[c]) begin
            ch_cart[c]  = 1'b1;
            ch_phase[c] = PH_PREHEAT;
            ch_ticks[c] = '0;
            ch_armed[c] = 1'b0;
        end else if (!level && ch_cart[c]) begin
            ch_cart[c]  = 1'b0;
            ch_phase[c] = PH_IDLE;
            ch_ticks[c] = '0;
            ch_armed[c] = 1'b0;
        end
    endtask

    task automatic advance_channels(input t_in_item it);
        logic      human;
        logic      dosing_any;
        logic      begin_dose;
        int        u;
        t_out_item msg;
        human      = set_guard && it.person_seen;
        dosing_any = 1'b0;
        u          = int'(it.unit_addr) - 1;
        case (it.action)
            ACT_TICK: begin
                for (int c = 0; c < NUM_CHAN; c++) begin
                    if (ch_phase[c] == PH_PREHEAT || ch_phase[c] == PH_DOSE ||
                        (ch_phase[c] == PH_WAIT && ch_armed[c])) begin
                        if (ch_ticks[c] != 16'hFFFF) ch_ticks[c] = ch_ticks[c] + 16'd1;
                    end
                end
                for (int c = 0; c < NUM_CHAN; c++) begin
                    if (unit_live[c / 2]) begin
                        begin_dose = 1'b0;
                        if (ch_phase[c] == PH_PREHEAT && ch_ticks[c] >= set_preheat) begin
                            if (human) begin
                                ch_phase[c] = PH_WAIT;
                                ch_armed[c] = 1'b0;
                            end else begin
                                begin_dose = 1'b1;
                            end
                        end
                        if (ch_phase[c] == PH_WAIT) begin
                            if (human) begin
                                ch_armed[c] = 1'b0;
                            end else if (!ch_armed[c]) begin
                                ch_armed[c] = 1'b1;
                                ch_ticks[c] = '0;
                            end else if (ch_ticks[c] >= set_wait) begin
                                begin_dose = 1'b1;
                            end
                        end
                        if (begin_dose) begin
                            ch_phase[c]     = PH_DOSE;
                            ch_armed[c]     = 1'b0;
                            ch_ticks[c]     = '0;
                            msg.kind        = KIND_START;
                            msg.cmd_unit    = 5'(c / 2 + 1);
                            msg.cmd_channel = 2'(c % 2 + 1);
                            msg.pump_on     = 1'b1;
                            msg.last        = 1'b0;
                            awaited_msgs.push_back(msg);
                        end
                        if (ch_phase[c] == PH_DOSE) begin
                            if (ch_ticks[c] >= set_dose) ch_phase[c] = PH_IDLE;
                            else dosing_any = 1'b1;
                        end
                    end
                end
                pump_live = dosing_any;
            end
            ACT_REPORT: begin
                if (u >= 0 && u < NUM_UNITS) begin
                    unit_live[u] = 1'b1;
                    apply_cart(2 * u, it.cart_one);
                    apply_cart(2 * u + 1, it.cart_two);
                end
            end
            ACT_OFFLINE: begin
                if (u >= 0 && u < NUM_UNITS) unit_live[u] = 1'b0;
            end
            ACT_CLEAR: begin
                for (int c = 0; c < NUM_CHAN; c++) begin
                    ch_phase[c] = PH_IDLE;
                    ch_armed[c] = 1'b0;
                    ch_ticks[c] = '0;
                end
                pump_live = 1'b0;
            end
        endcase
        msg.kind        = KIND_SUMMARY;
        msg.cmd_unit    = '0;
        msg.cmd_channel = '0;
        msg.pump_on     = pump_live;
        msg.last        = 1'b1;
        awaited_msgs.push_back(msg);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            if (i_rst_n && in_ch.valid && in_ch.ready) begin
                advance_channels(in_ch.data);
                items_taken++;
            end
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                if (awaited_msgs.size() == 0) begin
                    $error("result item with none expected: %p", res_ch.data);
                    fail_count++;
                end else begin
                    want = awaited_msgs.pop_front();
                    check_field("kind", want.kind, res_ch.data.kind);
                    check_field("cmd_unit", want.cmd_unit, res_ch.data.cmd_unit);
                    check_field("cmd_channel", want.cmd_channel, res_ch.data.cmd_channel);
                    check_field("pump_on", want.pump_on, res_ch.data.pump_on);
                    check_field("last", want.last, res_ch.data.last);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (items_taken == items_sent) begin
            if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
                in_data  <= pending_items.pop_front();
                in_valid <= 1'b1;
                items_sent++;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!hold_done && items_taken >= 150) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end else begin
            res_ready <= i_rst_n && (calm || $urandom_range(0, 99) >= 20);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_PREHEAT: set_preheat = value;
            CFG_SAFETY:  set_wait    = value;
            CFG_DOSE:    set_dose    = value;
            CFG_ENABLE:  set_guard   = value[0];
        endcase
    endtask

    task automatic set_timing(input logic [15:0] preheat, input logic [15:0] hold,
                              input logic [15:0] dose, input logic guard);
        write_reg(CFG_PREHEAT, preheat);
        write_reg(CFG_SAFETY, hold);
        write_reg(CFG_DOSE, dose);
        write_reg(CFG_ENABLE, {15'($urandom), guard});
    endtask

    task automatic queue_item(input logic [1:0] action, input logic [4:0] addr,
                              input logic c1, input logic c2, input logic person);
        t_in_item it;
        it.action      = action;
        it.unit_addr   = addr;
        it.cart_one    = c1;
        it.cart_two    = c2;
        it.person_seen = person;
        pending_items.push_back(it);
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && items_taken == items_sent &&
              awaited_msgs.size() == 0);
        repeat (40) @(negedge i_clk);
    endtask

    function automatic logic [4:0] pick_unit();
        if ($urandom_range(0, 1) == 0) return 5'($urandom_range(1, 4));
        return 5'($urandom_range(1, NUM_UNITS));
    endfunction

    task automatic run_random(input int count);
        int roll;
        t_in_item it;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                queue_item(ACT_TICK, 5'($urandom), 1'($urandom), 1'($urandom),
                           $urandom_range(0, 99) < 30);
            end else if (roll < 85) begin
                queue_item(ACT_REPORT, pick_unit(), $urandom_range(0, 99) < 65,
                           $urandom_range(0, 99) < 65, 1'($urandom));
            end else if (roll < 91) begin
                queue_item(ACT_OFFLINE, pick_unit(), 1'($urandom), 1'($urandom),
                           1'($urandom));
            end else if (roll < 94) begin
                queue_item(ACT_CLEAR, 5'($urandom), 1'($urandom), 1'($urandom),
                           1'($urandom));
            end else begin
                it = 10'($urandom);
                pending_items.push_back(it);
            end
        end
        drain();
    endtask

    function automatic logic [15:0] short_span();
        return 16'($urandom_range(0, 8));
    endfunction

    initial begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            ch_phase[c] = PH_IDLE;
            ch_cart[c]  = 1'b0;
            ch_armed[c] = 1'b0;
            ch_ticks[c] = '0;
        end
        for (int u = 0; u < NUM_UNITS; u++) unit_live[u] = 1'b0;
        pump_live   = 1'b0;
        set_preheat = RST_PREHEAT;
        set_wait    = RST_SAFETY;
        set_dose    = RST_DOSE;
        set_guard   = 1'b1;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        set_timing(16'd2, 16'd2, 16'd3, 1'b1);
        queue_item(ACT_REPORT, 5'd0, 1'b1, 1'b1, 1'b0);
        queue_item(ACT_REPORT, 5'd17, 1'b1, 1'b1, 1'b0);
        queue_item(ACT_OFFLINE, 5'd31, 1'b0, 1'b0, 1'b1);
        queue_item(ACT_REPORT, 5'd1, 1'b1, 1'b1, 1'b0);
        queue_item(ACT_REPORT, 5'd16, 1'b1, 1'b0, 1'b0);
        queue_item(ACT_REPORT, 5'd5, 1'b0, 1'b1, 1'b0);
        queue_item(ACT_OFFLINE, 5'd5, 1'b0, 1'b0, 1'b0);
        queue_item(ACT_TICK, 5'd0, 1'b0, 1'b0, 1'b0);
        queue_item(ACT_TICK, 5'd31, 1'b1, 1'b1, 1'b1);
        queue_item(ACT_TICK, 5'd0, 1'b0, 1'b0, 1'b1);
        queue_item(ACT_TICK, 5'd0, 1'b0, 1'b0, 1'b0);
        queue_item(ACT_TICK, 5'd0, 1'b0, 1'b0, 1'b0);
        queue_item(ACT_TICK, 5'd0, 1'b0, 1'b0, 1'b0);
        queue_item(ACT_REPORT, 5'd5, 1'b0, 1'b1, 1'b1);
        queue_item(ACT_TICK, 5'd0, 1'b0, 1'b0, 1'b0);
        queue_item(ACT_REPORT, 5'd1, 1'b0, 1'b1, 1'b0);
        queue_item(ACT_TICK, 5'd0, 1'b0, 1'b0, 1'b0);
        queue_item(ACT_TICK, 5'd0, 1'b0, 1'b0, 1'b0);
        queue_item(ACT_CLEAR, 5'd31, 1'b1, 1'b1, 1'b1);
        queue_item(ACT_TICK, 5'd0, 1'b0, 1'b0, 1'b0);
        queue_item(ACT_REPORT, 5'd1, 1'b1, 1'b1, 1'b0);
        queue_item(ACT_TICK, 5'd0, 1'b0, 1'b0, 1'b0);
        queue_item(ACT_TICK, 5'd0, 1'b0, 1'b0, 1'b0);
        queue_item(ACT_TICK, 5'd0, 1'b0, 1'b0, 1'b0);
        drain();

        set_timing(16'd0, 16'd0, 16'd0, 1'b0);
        run_random(PHASE_ITEMS);
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        run_random(PHASE_ITEMS);
        repeat (5) begin
            set_timing(short_span(), short_span(), short_span(), 1'($urandom_range(0, 1)));
            run_random(PHASE_ITEMS);
        end

        repeat (60) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
